[sv/hashed_text_embedding_assert.svh]
// Assertion macros for the hashed text embedding block.
// Each macro checks one implication on the rising edge of the given clock
// and is disabled while the active-low reset is asserted.
`ifndef HASHED_TEXT_EMBEDDING_ASSERT_SVH
`define HASHED_TEXT_EMBEDDING_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication
`define HTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define HTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define HTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/hte_pkg.sv]
`default_nettype none

package hte_pkg;

    // Hash start value and the FNV-1a prime, which is 2^40 + 0x1B3
    localparam logic [63:0] HASH_BASIS      = 64'd1469598103934665603;
    localparam int          HASH_PRIME_SHL  = 40;
    localparam logic [8:0]  HASH_PRIME_LO   = 9'h1B3;

    // Bin increment: (hash mod VALUE_SPAN) - VALUE_OFFSET, in thousandths
    localparam int          VSW             = 11;
    localparam logic [VSW:0] VALUE_SPAN     = 12'd2000;
    localparam logic signed [VSW:0] VALUE_OFFSET = 12'sd1000;

    // Output grouping and Q1.15 format
    localparam int          GROUP           = 6;
    localparam int          QW              = 16;
    localparam logic signed [QW-1:0] Q_MAX  = 16'sh7FFF;

    // Quotient b^2 * 2^30 / S has 31 bits, its root 16 bits
    localparam int          YW              = 31;
    localparam int          FRAC_SHIFT      = 30;

    // Main controller states
    typedef enum logic [11:0] {
        S_CLR   = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_MOD   = 12'b0000_0000_0100,
        S_BRD   = 12'b0000_0000_1000,
        S_BWR   = 12'b0000_0001_0000,
        S_SUM   = 12'b0000_0010_0000,
        S_ERD   = 12'b0000_0100_0000,
        S_ESQ1  = 12'b0000_1000_0000,
        S_ESQ2  = 12'b0001_0000_0000,
        S_EROOT = 12'b0010_0000_0000,
        S_ESTO  = 12'b0100_0000_0000,
        S_SPARE = 12'b1000_0000_0000
    } t_state;

    // Normalizer unit states
    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_DIV  = 3'b010,
        R_SQRT = 3'b100
    } t_rstate;

endpackage

`default_nettype wire

[sv/hte_root.sv]
`default_nettype none

// Computes q = floor(sqrt(floor(b2 * 2^30 / s))), which equals the largest
// q with q^2 * s <= b2 * 2^30. Requires b2 <= s and s != 0.
// Restoring division, one quotient bit a cycle, then a bitwise root search.
module hte_root
    import hte_pkg::*;
#(
    parameter int B2W = 48,
    parameter int SW  = 57
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [B2W-1:0]    i_b2,
    input  wire logic [SW-1:0]     i_s,
    output logic                   o_done,
    output logic [QW-1:0]          o_q
);

    t_rstate          r_state;
    logic [SW-1:0]    r_rem;
    logic [YW-1:0]    r_num;
    logic [YW-1:0]    r_y;
    logic [QW-1:0]    r_root;
    logic [4:0]       r_cnt;
    logic             r_done;

    logic [SW:0]      n_rem2;
    logic [SW:0]      n_diff;
    logic             n_qbit;
    logic [QW-1:0]    n_trial;
    logic [2*QW-1:0]  n_tsq;

    // Division step and root trial
    always_comb begin
        n_rem2  = {r_rem, r_num[YW-1]};
        n_diff  = n_rem2 - {1'b0, i_s};
        n_qbit  = (n_rem2 >= {1'b0, i_s});
        n_trial = r_root | (QW'(1) << r_cnt[3:0]);
        n_tsq   = n_trial * n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                R_IDLE: begin
                    if (i_start) begin
                        r_rem   <= SW'(i_b2 >> 1);
                        r_num   <= {i_b2[0], {FRAC_SHIFT{1'b0}}};
                        r_y     <= '0;
                        r_cnt   <= 5'(YW - 1);
                        r_state <= R_DIV;
                    end
                end
                R_DIV: begin
                    r_rem <= n_qbit ? n_diff[SW-1:0] : n_rem2[SW-1:0];
                    r_num <= {r_num[YW-2:0], 1'b0};
                    r_y   <= {r_y[YW-2:0], n_qbit};
                    if (r_cnt == 5'd0) begin
                        r_root  <= '0;
                        r_cnt   <= 5'(QW - 1);
                        r_state <= R_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                R_SQRT: begin
                    if (n_tsq <= 32'(r_y)) begin
                        r_root <= n_trial;
                    end
                    if (r_cnt == 5'd0) begin
                        r_done  <= 1'b1;
                        r_state <= R_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                default: begin
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

    // A quotient of exactly 2^30 has root 32768
    assign o_q    = r_y[YW-1] ? 16'h8000 : r_root;
    assign o_done = r_done;

endmodule

`default_nettype wire

[sv/hashed_text_embedding.sv]
`default_nettype none
`include "hashed_text_embedding_assert.svh"

// Hashed text embedding: FNV-1a-style feature hashing into DIM bins, then an
// L2-normalized Q1.15 output vector.
// Input channel: a transaction is taken when start is high and busy is low.
// Each transaction carries one text byte (if i_byte_valid) and a last flag.
// A valid byte keeps busy high after acceptance for the remainder reduction
// (one hash byte a cycle), then a bin read and a bin write to the bin
// memory (one read, one write port). An item with neither flag is dropped.
// A last item starts the output pass: a sum of squares over all bins,
// then per element a restoring division and a bitwise root search.
// Results leave six elements at a time, each valid for one cycle with
// o_strobe; o_final_result marks the last of ceil(DIM/6) results. The
// receiver cannot stall, so results are simply presented and dropped.
// Bins are zeroed as they are read for output; the hash returns to the
// offset basis after the last result.
// After reset a clearing pass writes zero to all DIM bins with busy high.
module hashed_text_embedding
    import hte_pkg::*;
#(
    parameter int DIM       = 384,
    parameter int BIN_WIDTH = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [7:0]            i_text_byte,
    input  wire logic                  i_byte_valid,
    input  wire logic                  i_last_byte,
    output logic                       o_strobe,
    output logic [8:0]                 o_first_element,
    output logic signed [QW-1:0]       o_value_0,
    output logic signed [QW-1:0]       o_value_1,
    output logic signed [QW-1:0]       o_value_2,
    output logic signed [QW-1:0]       o_value_3,
    output logic signed [QW-1:0]       o_value_4,
    output logic signed [QW-1:0]       o_value_5,
    output logic                       o_final_result
);

    localparam int BW    = BIN_WIDTH;
    localparam int AW    = $clog2(DIM);
    localparam int RDW   = $clog2(DIM);
    localparam int NRES  = (DIM + GROUP - 1) / GROUP;
    localparam int EW    = $clog2(NRES * GROUP);
    localparam int LO    = BW / 2;
    localparam int HI    = BW - LO;
    localparam int B2W   = 2 * BW;
    localparam int SW    = 2 * BW + $clog2(DIM);
    localparam logic [RDW:0]  DIM_W     = (RDW + 1)'(DIM);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DIM - 1);
    localparam logic [EW-1:0] LAST_ELEM = EW'(NRES * GROUP - 1);
    localparam logic [EW:0]   DIM_E     = (EW + 1)'(DIM);

    // Bin memory
    logic [BW-1:0]   mem [DIM];
    logic [BW-1:0]   r_rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [BW-1:0]   mem_wd;
    logic            mem_re;
    logic [AW-1:0]   mem_ra;

    t_state          r_state;
    logic [63:0]     r_hash;
    logic [63:0]     r_msh;
    logic [2:0]      r_mcnt;
    logic [RDW-1:0]  r_rm_d;
    logic [VSW-1:0]  r_rm_v;
    logic            r_last;
    logic [AW-1:0]   r_addr;
    logic            r_issue_done;
    logic            r_v1;
    logic            r_v2;
    logic [SW-1:0]   r_s;
    logic [2*HI-1:0] r_pa;
    logic [HI+LO-1:0] r_pc;
    logic [2*LO-1:0] r_pb;
    logic [EW-1:0]   r_elem;
    logic [2:0]      r_lane;
    logic            r_zero;
    logic            r_neg;
    logic            r_root_go;
    logic signed [QW-1:0] r_val [GROUP];
    logic signed [QW-1:0] r_out_val [GROUP];
    logic            r_out_vld;
    logic            r_out_final;
    logic [8:0]      r_out_first;
    logic [8:0]      r_first;

    logic [63:0]     n_hash;
    logic [63:0]     hx;
    logic [RDW-1:0]  n_rm_d;
    logic [VSW-1:0]  n_rm_v;
    logic [BW-1:0]   rd_mag;
    logic [B2W-1:0]  sq;
    logic signed [VSW:0] bin_add;
    logic [BW:0]     bin_sum;
    logic [BW-1:0]   bin_sat;
    logic            root_done;
    logic [QW-1:0]   root_q;
    logic signed [QW-1:0] elem_val;

    // Next FNV-1a hash: xor the byte, multiply by 2^40 + 0x1B3
    always_comb begin
        hx     = r_hash ^ {56'd0, i_text_byte};
        n_hash = (hx << HASH_PRIME_SHL) + hx * 64'(HASH_PRIME_LO);
    end

    // Reduce eight hash bits a cycle modulo DIM and modulo the value span
    always_comb begin
        logic [RDW:0]  td;
        logic [VSW:0]  tv;
        n_rm_d = r_rm_d;
        n_rm_v = r_rm_v;
        for (int i = 0; i < 8; i++) begin
            td = {n_rm_d, r_msh[63-i]};
            if (td >= DIM_W) begin
                td = td - DIM_W;
            end
            n_rm_d = td[RDW-1:0];
            tv = {n_rm_v, r_msh[63-i]};
            if (tv >= VALUE_SPAN) begin
                tv = tv - VALUE_SPAN;
            end
            n_rm_v = tv[VSW-1:0];
        end
    end

    // Saturating bin update
    always_comb begin
        bin_add = $signed({1'b0, r_rm_v}) - VALUE_OFFSET;
        bin_sum = {r_rd_data[BW-1], r_rd_data} + {{(BW-VSW){bin_add[VSW]}}, bin_add};
        if (bin_sum[BW] != bin_sum[BW-1]) begin
            bin_sat = bin_sum[BW] ? {1'b1, {(BW-1){1'b0}}} : {1'b0, {(BW-1){1'b1}}};
        end else begin
            bin_sat = bin_sum[BW-1:0];
        end
    end

    // Magnitude of the read bin and the combined square
    always_comb begin
        rd_mag = r_rd_data[BW-1] ? (~r_rd_data + BW'(1)) : r_rd_data;
        sq     = (B2W'(r_pa) << (2 * LO)) + (B2W'(r_pc) << (LO + 1)) + B2W'(r_pb);
    end

    // Memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = r_addr;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_BRD: begin
                mem_re = 1'b1;
                mem_ra = r_rm_d;
            end
            S_BWR: begin
                mem_we = 1'b1;
                mem_wa = r_rm_d;
                mem_wd = bin_sat;
            end
            S_SUM: begin
                mem_re = !r_issue_done;
            end
            S_ERD: begin
                mem_re = ({1'b0, r_elem} < DIM_E) && (r_s != '0);
                mem_ra = r_elem[AW-1:0];
            end
            S_ESQ1: begin
                mem_we = 1'b1;
                mem_wa = r_elem[AW-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // Squaring partial products, registered every cycle
    always_ff @(posedge i_clk) begin
        r_pa <= rd_mag[BW-1:LO] * rd_mag[BW-1:LO];
        r_pc <= rd_mag[BW-1:LO] * rd_mag[LO-1:0];
        r_pb <= rd_mag[LO-1:0] * rd_mag[LO-1:0];
    end

    // Signed, saturated Q1.15 element from the root
    always_comb begin
        if (r_zero) begin
            elem_val = '0;
        end else if (r_neg) begin
            elem_val = $signed(QW'(17'd0 - {1'b0, root_q}));
        end else if (root_q > QW'(Q_MAX)) begin
            elem_val = Q_MAX;
        end else begin
            elem_val = $signed(root_q);
        end
    end

    hte_root #(
        .B2W (B2W),
        .SW  (SW)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_root_go),
        .i_b2    (sq),
        .i_s     (r_s),
        .o_done  (root_done),
        .o_q     (root_q)
    );

    // Main controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_addr       <= '0;
            r_hash       <= HASH_BASIS;
            r_mcnt       <= '0;
            r_last       <= 1'b0;
            r_issue_done <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_s          <= '0;
            r_elem       <= '0;
            r_lane       <= '0;
            r_first      <= '0;
            r_root_go    <= 1'b0;
            r_out_vld    <= 1'b0;
            r_out_final  <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            r_root_go <= 1'b0;
            r_v1      <= (r_state == S_SUM) && !r_issue_done;
            r_v2      <= r_v1;
            case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == LAST_ADDR) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_last <= i_last_byte;
                        r_addr <= '0;
                        r_issue_done <= 1'b0;
                        r_s <= '0;
                        if (i_byte_valid) begin
                            r_hash  <= n_hash;
                            r_msh   <= n_hash;
                            r_rm_d  <= '0;
                            r_rm_v  <= '0;
                            r_mcnt  <= '0;
                            r_state <= S_MOD;
                        end else if (i_last_byte) begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_MOD: begin
                    r_rm_d <= n_rm_d;
                    r_rm_v <= n_rm_v;
                    r_msh  <= r_msh << 8;
                    r_mcnt <= r_mcnt + 3'd1;
                    if (r_mcnt == 3'd7) begin
                        r_state <= S_BRD;
                    end
                end
                S_BRD: begin
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    r_state <= r_last ? S_SUM : S_IDLE;
                end
                S_SUM: begin
                    // Stream all bins through the squarer into the sum
                    if (!r_issue_done) begin
                        r_addr <= r_addr + AW'(1);
                        if (r_addr == LAST_ADDR) begin
                            r_issue_done <= 1'b1;
                        end
                    end
                    if (r_v2) begin
                        r_s <= r_s + SW'(sq);
                    end
                    if (r_issue_done && !r_v1 && !r_v2) begin
                        r_elem  <= '0;
                        r_lane  <= '0;
                        r_first <= '0;
                        r_state <= S_ERD;
                    end
                end
                S_ERD: begin
                    if (mem_re) begin
                        r_zero  <= 1'b0;
                        r_state <= S_ESQ1;
                    end else begin
                        r_zero  <= 1'b1;
                        r_state <= S_ESTO;
                    end
                end
                S_ESQ1: begin
                    r_neg   <= r_rd_data[BW-1];
                    r_state <= S_ESQ2;
                end
                S_ESQ2: begin
                    r_root_go <= 1'b1;
                    r_state   <= S_EROOT;
                end
                S_EROOT: begin
                    if (root_done) begin
                        r_state <= S_ESTO;
                    end
                end
                S_ESTO: begin
                    r_val[r_lane] <= elem_val;
                    r_elem <= r_elem + EW'(1);
                    if (r_lane == 3'(GROUP - 1)) begin
                        // Present one result of six elements
                        for (int k = 0; k < GROUP - 1; k++) begin
                            r_out_val[k] <= r_val[k];
                        end
                        r_out_val[GROUP-1] <= elem_val;
                        r_out_vld   <= 1'b1;
                        r_out_first <= r_first;
                        r_out_final <= (r_elem == LAST_ELEM);
                        r_first     <= r_first + 9'(GROUP);
                        r_lane      <= '0;
                        if (r_elem == LAST_ELEM) begin
                            r_hash  <= HASH_BASIS;
                            r_s     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ERD;
                        end
                    end else begin
                        r_lane  <= r_lane + 3'd1;
                        r_state <= S_ERD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_out_vld;
    assign o_first_element = r_out_first;
    assign o_value_0       = r_out_val[0];
    assign o_value_1       = r_out_val[1];
    assign o_value_2       = r_out_val[2];
    assign o_value_3       = r_out_val[3];
    assign o_value_4       = r_out_val[4];
    assign o_value_5       = r_out_val[5];
    assign o_final_result  = r_out_final;

    // The last result leaves the block idle with the hash back at its basis
    `HTE_ASSERT_IMP(a_final_idle, i_clk, i_rst_n, o_strobe && o_final_result, (r_state == S_IDLE) && (r_hash == HASH_BASIS), "final result without return to idle")
    // A bin read is always followed by its write-back
    `HTE_ASSERT_NXT(a_bin_rmw, i_clk, i_rst_n, r_state == S_BRD, r_state == S_BWR, "bin read without write-back")
    // A result always closes a full group of lanes
    `HTE_ASSERT_IMP(a_lane_wrap, i_clk, i_rst_n, o_strobe, r_lane == 3'd0, "result presented mid-group")
    // The normalizer only finishes while the controller waits on it
    `HTE_ASSERT_IMP(a_root_wait, i_clk, i_rst_n, root_done, r_state == S_EROOT, "normalizer done outside wait state")

endmodule

`default_nettype wire
